// ===== src/hmrp_pkg.sv =====
// Types and constants shared by the height-map rectangle packer.
// No dependencies; every other file of the block imports this package.
package hmrp_pkg;

    localparam int RECT_WIDTH_BITS  = 11;
    localparam int RECT_HEIGHT_BITS = 16;
    localparam int STRIP_BITS       = 11;
    localparam int MARGIN_BITS      = 8;
    localparam int PLACE_X_BITS     = 10;
    localparam int PLACE_Y_BITS     = 16;
    localparam int USED_BITS        = 16;
    localparam int STATUS_BITS      = 2;
    // footprint sizes: field plus twice the gutter, with room for any bit pattern
    localparam int FW_BITS          = 12;
    localparam int FH_BITS          = 17;

    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 11;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIP_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BORDER_MARGIN = 2'd1;
    localparam logic [STRIP_BITS-1:0]     STRIP_RESET       = 11'd1024;

    localparam logic [STATUS_BITS-1:0] STATUS_PLACED = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_WIDE   = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_OVER   = 2'd3;

    typedef struct packed {
        logic                        first_of_set;
        logic [RECT_WIDTH_BITS-1:0]  rect_width;
        logic [RECT_HEIGHT_BITS-1:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic [PLACE_X_BITS-1:0] place_x;
        logic [PLACE_Y_BITS-1:0] place_y;
        logic [USED_BITS-1:0]    peak_height;
        logic [STATUS_BITS-1:0]  status;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_SUFFIX,
        OP_PREFIX,
        OP_WRITE
    } op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_SUFFIX,
        S_SUF_DRAIN,
        S_PREFIX,
        S_PRE_DRAIN,
        S_CHECK,
        S_WRITE,
        S_SWEEP,
        S_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic load;
        op_t  init_op;
        op_t  run_op;
        logic zero_fill;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic first;
        logic over;
        logic last;
    } sts_t;

endpackage

// ===== src/hmrp_ctrl.sv =====
// Sequencing state machine of the rectangle packer.
// Depends on hmrp_pkg; drives the datapath through cmd_t and reads sts_t.
module hmrp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  hmrp_pkg::sts_t  sts,
    output hmrp_pkg::cmd_t  cmd
);
    import hmrp_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.init_op   = OP_NONE;
        cmd.run_op    = OP_NONE;
        cmd.zero_fill = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.run_op    = OP_CLEAR;
                cmd.zero_fill = 1'b1;
                if (sts.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.bad)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.first)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.init_op = OP_SUFFIX;
                    state_next  = S_SUFFIX;
                end
            end
            S_SUFFIX:
            begin
                cmd.run_op = OP_SUFFIX;
                if (sts.last)
                begin
                    state_next = S_SUF_DRAIN;
                end
            end
            S_SUF_DRAIN:
            begin
                // last suffix entry lands this cycle
                cmd.init_op = OP_PREFIX;
                state_next  = S_PREFIX;
            end
            S_PREFIX:
            begin
                cmd.run_op = OP_PREFIX;
                if (sts.last)
                begin
                    state_next = S_PRE_DRAIN;
                end
            end
            S_PRE_DRAIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.over)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.first)
                begin
                    cmd.init_op = OP_CLEAR;
                    state_next  = S_SWEEP;
                end
                else
                begin
                    cmd.init_op = OP_WRITE;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.run_op = OP_WRITE;
                if (sts.last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_SWEEP:
            begin
                cmd.run_op = OP_CLEAR;
                if (sts.last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== src/hmrp_datapath.sv =====
// Column store, sliding-window maximum scan and placement update of the packer.
// Depends on hmrp_pkg; sequenced by hmrp_ctrl through cmd_t / sts_t.
module hmrp_datapath #(
    parameter int MAX_COLUMNS = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hmrp_pkg::cmd_t                   cmd,
    output hmrp_pkg::sts_t                   sts,
    input  hmrp_pkg::in_item_t               item,
    input  logic [hmrp_pkg::STRIP_BITS-1:0]  strip_width,
    input  logic [hmrp_pkg::MARGIN_BITS-1:0] border_margin,
    output logic                             done,
    output hmrp_pkg::out_item_t              result
);
    import hmrp_pkg::*;

    localparam int ADDR_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW        = (ADDR_BITS + 1 > FW_BITS) ? ADDR_BITS + 1 : FW_BITS;
    localparam int TOP_BITS  = ((HEIGHT_BITS > FH_BITS) ? HEIGHT_BITS : FH_BITS) + 1;
    localparam int YS_BITS   = ((HEIGHT_BITS > PLACE_Y_BITS) ? HEIGHT_BITS : PLACE_Y_BITS) + 1;

    // column store and block-suffix maximum store
    logic [HEIGHT_BITS-1:0] h_mem [MAX_COLUMNS];
    logic [HEIGHT_BITS-1:0] s_mem [MAX_COLUMNS];
    logic [HEIGHT_BITS-1:0] h_q;
    logic [HEIGHT_BITS-1:0] s_q;

    // item registers
    logic                   first_reg;
    logic                   zero_reg;
    logic                   wide_reg;
    logic [CW-1:0]          fw_reg;
    logic [FH_BITS-1:0]     fh_reg;
    logic [MARGIN_BITS-1:0] bm_reg;
    logic [CW-1:0]          eff_reg;

    // scan control
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          k_reg;
    logic [CW-1:0]          k0_reg;
    logic                   suf_v_reg;
    logic [ADDR_BITS-1:0]   suf_i_reg;
    logic                   suf_bend_reg;
    logic [HEIGHT_BITS-1:0] suf_acc_reg;
    logic                   pre_v_reg;
    logic [CW-1:0]          pre_j_reg;
    logic                   pre_bstart_reg;
    logic                   pre_win_reg;
    logic [HEIGHT_BITS-1:0] pre_acc_reg;
    logic                   have_reg;
    logic [CW-1:0]          best_x_reg;
    logic [HEIGHT_BITS-1:0] best_y_reg;
    logic [HEIGHT_BITS-1:0] tall_reg;
    logic                   done_reg;
    out_item_t              res_reg;

    // combinational
    logic [CW-1:0]          eff_in;
    logic [FW_BITS-1:0]     fw_in;
    logic [FH_BITS-1:0]     fh_in;
    logic [TOP_BITS-1:0]    top;
    logic [HEIGHT_BITS-1:0] top_h;
    logic                   over;
    logic [CW-1:0]          wr_end;
    logic [CW-1:0]          s_raddr_full;
    logic                   h_we;
    logic [HEIGHT_BITS-1:0] h_wdata;
    logic [HEIGHT_BITS-1:0] suf_val;
    logic [HEIGHT_BITS-1:0] pre_val;
    logic [HEIGHT_BITS-1:0] win_y;
    logic [CW-1:0]          win_x;
    logic                   better;
    logic [STATUS_BITS-1:0] status_w;
    logic [HEIGHT_BITS-1:0] tall_new;
    logic [YS_BITS-1:0]     place_y_full;
    logic [CW-1:0]          place_x_full;

    assign eff_in = (32'(strip_width) > 32'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(strip_width);
    assign fw_in  = FW_BITS'(item.rect_width) + FW_BITS'({border_margin, 1'b0});
    assign fh_in  = FH_BITS'(item.rect_height) + FH_BITS'({border_margin, 1'b0});

    assign top    = TOP_BITS'(best_y_reg) + TOP_BITS'(fh_reg);
    assign top_h  = top[HEIGHT_BITS-1:0];
    assign over   = |top[TOP_BITS-1:HEIGHT_BITS];
    assign wr_end = best_x_reg + fw_reg - CW'(1);

    assign s_raddr_full = i_reg - fw_reg + CW'(1);

    assign h_we    = (cmd.run_op == OP_CLEAR) || (cmd.run_op == OP_WRITE);
    assign h_wdata = ((cmd.run_op == OP_WRITE) || (!cmd.zero_fill && (i_reg < fw_reg)))
                     ? top_h : '0;

    assign suf_val = (suf_bend_reg || (h_q > suf_acc_reg)) ? h_q : suf_acc_reg;
    assign pre_val = (pre_bstart_reg || (h_q > pre_acc_reg)) ? h_q : pre_acc_reg;
    assign win_y   = (s_q > pre_val) ? s_q : pre_val;
    assign win_x   = pre_j_reg - (fw_reg - CW'(1));
    assign better  = !have_reg || (win_y < best_y_reg);

    assign status_w = zero_reg ? STATUS_ZERO :
                      wide_reg ? STATUS_WIDE :
                      over     ? STATUS_OVER : STATUS_PLACED;
    assign tall_new = (first_reg || (top_h > tall_reg)) ? top_h : tall_reg;

    assign place_x_full = best_x_reg + CW'(bm_reg);
    assign place_y_full = YS_BITS'(best_y_reg) + YS_BITS'(bm_reg);

    always_comb
    begin
        sts.bad   = zero_reg || wide_reg;
        sts.first = first_reg;
        sts.over  = over;
        case (cmd.run_op)
            OP_CLEAR:  sts.last = (i_reg == CW'(MAX_COLUMNS - 1));
            OP_SUFFIX: sts.last = (i_reg == '0);
            OP_PREFIX: sts.last = (i_reg == eff_reg - CW'(1));
            OP_WRITE:  sts.last = (i_reg == wr_end);
            default:   sts.last = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            h_mem[i_reg[ADDR_BITS-1:0]] <= h_wdata;
        end
        h_q <= h_mem[i_reg[ADDR_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (suf_v_reg)
        begin
            s_mem[suf_i_reg] <= suf_val;
        end
        s_q <= s_mem[s_raddr_full[ADDR_BITS-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            k_reg     <= '0;
            k0_reg    <= '0;
            suf_v_reg <= 1'b0;
            pre_v_reg <= 1'b0;
            have_reg  <= 1'b0;
            tall_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            suf_v_reg <= (cmd.run_op == OP_SUFFIX);
            pre_v_reg <= (cmd.run_op == OP_PREFIX);
            done_reg  <= cmd.emit;

            case (cmd.init_op)
                OP_CLEAR:
                begin
                    i_reg <= '0;
                end
                OP_SUFFIX:
                begin
                    i_reg <= eff_reg - CW'(1);
                    k_reg <= '0;
                end
                OP_PREFIX:
                begin
                    i_reg <= '0;
                    k_reg <= k0_reg;
                end
                OP_WRITE:
                begin
                    i_reg <= best_x_reg;
                end
                default:
                begin
                    case (cmd.run_op)
                        OP_SUFFIX:
                        begin
                            i_reg <= i_reg - CW'(1);
                            k_reg <= (k_reg == fw_reg - CW'(1)) ? '0 : k_reg + CW'(1);
                            if (i_reg == '0)
                            begin
                                k0_reg <= k_reg;
                            end
                        end
                        OP_PREFIX:
                        begin
                            i_reg <= i_reg + CW'(1);
                            k_reg <= (k_reg == '0) ? fw_reg - CW'(1) : k_reg - CW'(1);
                        end
                        OP_CLEAR, OP_WRITE:
                        begin
                            i_reg <= i_reg + CW'(1);
                        end
                        default:
                        begin
                            i_reg <= i_reg;
                        end
                    endcase
                end
            endcase

            if (cmd.init_op == OP_PREFIX)
            begin
                have_reg <= 1'b0;
            end
            else if (pre_v_reg && pre_win_reg && better)
            begin
                have_reg <= 1'b1;
            end

            if (cmd.emit && (status_w == STATUS_PLACED))
            begin
                tall_reg <= tall_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg  <= item.first_of_set;
            zero_reg   <= (item.rect_width == '0) || (item.rect_height == '0);
            wide_reg   <= (CW'(fw_in) > eff_in);
            fw_reg     <= CW'(fw_in);
            fh_reg     <= fh_in;
            bm_reg     <= border_margin;
            eff_reg    <= eff_in;
            best_x_reg <= '0;
            best_y_reg <= '0;
        end

        if (cmd.run_op == OP_SUFFIX)
        begin
            suf_i_reg    <= i_reg[ADDR_BITS-1:0];
            suf_bend_reg <= (k_reg == '0);
        end
        if (suf_v_reg)
        begin
            suf_acc_reg <= suf_val;
        end

        if (cmd.run_op == OP_PREFIX)
        begin
            pre_j_reg      <= i_reg;
            pre_bstart_reg <= (k_reg == fw_reg - CW'(1)) || (i_reg == '0);
            pre_win_reg    <= (i_reg >= fw_reg - CW'(1));
        end
        if (pre_v_reg)
        begin
            pre_acc_reg <= pre_val;
            // strict compare keeps the leftmost start column on a tie
            if (pre_win_reg && better)
            begin
                best_x_reg <= win_x;
                best_y_reg <= win_y;
            end
        end

        if (cmd.emit)
        begin
            res_reg.status <= status_w;
            if (status_w == STATUS_PLACED)
            begin
                res_reg.place_x     <= place_x_full[PLACE_X_BITS-1:0];
                res_reg.place_y     <= place_y_full[PLACE_Y_BITS-1:0];
                res_reg.peak_height <= USED_BITS'(tall_new);
            end
            else
            begin
                res_reg.place_x     <= '0;
                res_reg.place_y     <= '0;
                res_reg.peak_height <= USED_BITS'(tall_reg);
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_suffix_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
        suf_v_reg |-> (CW'(suf_i_reg) < eff_reg))
        else $error("suffix write beyond strip");

    a_window_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (pre_v_reg && pre_win_reg) |-> (win_x <= eff_reg - fw_reg))
        else $error("window start past last fitting column");

    a_write_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.run_op == OP_WRITE) |-> (i_reg < eff_reg))
        else $error("column update beyond strip");

    a_tallest_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (status_w == STATUS_PLACED)) |=> (tall_reg >= $past(top_h)))
        else $error("tallest height below placed top");

endmodule

// ===== src/height_map_rect_packer_unit.sv =====
// Bottom-left height-map rectangle packer: top level with configuration registers.
// Depends on hmrp_pkg, hmrp_ctrl and hmrp_datapath.
//
// Raise start with a rectangle while busy is low; exactly one result follows,
// shown for a single cycle with done high, and the receiver must take it then.
// A normal placement runs a backward pass then a forward pass over the
// effective strip (min of strip_width and MAX_COLUMNS), one column a cycle on
// the column store's single read port, then writes the footprint columns
// (rectangle width plus twice the gutter). A first-of-set item instead sweeps
// all MAX_COLUMNS entries of the store. Errors caught on entry (zero size,
// too wide) go straight to the result. After reset the column store is
// cleared entry by entry with busy high; configuration writes are taken at
// any time but belong in idle periods.
module height_map_rect_packer_unit #(
    parameter int MAX_COLUMNS = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  hmrp_pkg::in_item_t                  item,
    output logic                                done,
    output hmrp_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hmrp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hmrp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import hmrp_pkg::*;

    logic [STRIP_BITS-1:0]  strip_reg;
    logic [MARGIN_BITS-1:0] margin_reg;
    cmd_t                   cmd;
    sts_t                   sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg  <= STRIP_RESET;
            margin_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STRIP_WIDTH:   strip_reg  <= cfg_data[STRIP_BITS-1:0];
                CFG_BORDER_MARGIN: margin_reg <= cfg_data[MARGIN_BITS-1:0];
                default:           strip_reg  <= strip_reg;
            endcase
        end
    end

    hmrp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    hmrp_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .item          (item),
        .strip_width   (strip_reg),
        .border_margin (margin_reg),
        .done          (done),
        .result        (result)
    );

endmodule

// ===== dv/height_map_rect_packer_unit_test.sv =====
// Self-checking testbench for height_map_rect_packer_unit: directed and random rectangles,
// with the column store, gutter and strip width tracked by a scoreboard class.
// Depends on hmrp_pkg and the packer RTL only.
module height_map_rect_packer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hmrp_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int HEIGHT_MAX   = 65535;
    localparam int LIMIT_CYCLES = 6000000;
    localparam int RANDOM_RECTS = 255;
    // index with no register behind it
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    class placement_scoreboard;
        logic [15:0]           column_top [MAX_COLS];
        logic [15:0]           tallest;
        logic [STRIP_BITS-1:0] strip_width;
        logic [7:0]            margin;
        int                    block_lead [MAX_COLS];
        int                    block_trail [MAX_COLS];
        out_item_t             expected_placements [$];
        int                    failures;
        int                    checked;
        int                    status_count [4];

        function new();
            foreach (column_top[c])
                column_top[c] = '0;
            foreach (status_count[s])
                status_count[s] = 0;
            tallest     = '0;
            strip_width = STRIP_RESET;
            margin      = '0;
            failures    = 0;
            checked     = 0;
        endfunction

        function void apply_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_STRIP_WIDTH)
                strip_width = data;
            else if (idx == CFG_BORDER_MARGIN)
                margin = data[7:0];
        endfunction

        function int pending();
            return expected_placements.size();
        endfunction

        // Work out where the rectangle lands and update the column store.
        function void note_rect(in_item_t it);
            out_item_t want;
            int        eff;
            int        fw;
            int        fh;
            int        top;
            int        best_x;
            int        best_y;
            int        y;
            int        x;
            int        c;
            want = '0;
            eff = (strip_width > MAX_COLS) ? MAX_COLS : int'(strip_width);
            want.peak_height = tallest;
            if (it.rect_width == 0 || it.rect_height == 0)
                want.status = STATUS_ZERO;
            else
            begin
                fw = int'(it.rect_width) + 2 * int'(margin);
                fh = int'(it.rect_height) + 2 * int'(margin);
                if (fw > eff)
                    want.status = STATUS_WIDE;
                else
                begin
                    best_x = 0;
                    best_y = 0;
                    if (!it.first_of_set)
                    begin
                        // window maximum from per-block running maxima, blocks of fw columns
                        for (c = 0; c < eff; c++)
                        begin
                            if (c % fw == 0 || column_top[c] > block_lead[c-1])
                                block_lead[c] = column_top[c];
                            else
                                block_lead[c] = block_lead[c-1];
                        end
                        for (c = eff - 1; c >= 0; c--)
                        begin
                            if (c == eff - 1 || (c + 1) % fw == 0 || column_top[c] > block_trail[c+1])
                                block_trail[c] = column_top[c];
                            else
                                block_trail[c] = block_trail[c+1];
                        end
                        for (x = 0; x <= eff - fw; x++)
                        begin
                            y = block_trail[x];
                            if (block_lead[x+fw-1] > y)
                                y = block_lead[x+fw-1];
                            if (x == 0 || y < best_y)
                            begin
                                best_x = x;
                                best_y = y;
                            end
                        end
                    end
                    top = best_y + fh;
                    if (top > HEIGHT_MAX)
                        want.status = STATUS_OVER;
                    else
                    begin
                        if (it.first_of_set)
                        begin
                            foreach (column_top[k])
                                column_top[k] = '0;
                            tallest = '0;
                        end
                        for (c = 0; c < fw; c++)
                            column_top[best_x+c] = 16'(top);
                        if (top > tallest)
                            tallest = 16'(top);
                        want.place_x     = PLACE_X_BITS'(best_x + int'(margin));
                        want.place_y     = PLACE_Y_BITS'(best_y + int'(margin));
                        want.peak_height = tallest;
                        want.status      = STATUS_PLACED;
                    end
                end
            end
            expected_placements.push_back(want);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t ns: %s differs: got %0d, want %0d", $time, what, got, want);
            failures++;
        endtask

        task check_placement(out_item_t got);
            out_item_t want;
            if (expected_placements.size() == 0)
            begin
                report("result with no rectangle pending, status", 32'(got.status), 32'd0);
                return;
            end
            want = expected_placements.pop_front();
            checked++;
            status_count[want.status]++;
            if (got.place_x !== want.place_x)
                report("place_x", 32'(got.place_x), 32'(want.place_x));
            if (got.place_y !== want.place_y)
                report("place_y", 32'(got.place_y), 32'(want.place_y));
            if (got.peak_height !== want.peak_height)
                report("peak_height", 32'(got.peak_height), 32'(want.peak_height));
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
        endtask

        task close_out();
            if (expected_placements.size() != 0)
                report("placements never produced", 32'(expected_placements.size()), 32'd0);
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    in_item_t                  item = '0;
    logic                      done;
    out_item_t                 result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    placement_scoreboard sb;
    int                  rects_sent = 0;
    int                  firsts_sent = 0;
    int                  settings_run = 0;
    int                  cycle_count = 0;

    height_map_rect_packer_unit #(
        .MAX_COLUMNS(MAX_COLS),
        .HEIGHT_BITS(16)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_placement(result);
    end

    function automatic in_item_t rect(bit first, int w, int h);
        in_item_t r;
        r.first_of_set = first;
        r.rect_width   = RECT_WIDTH_BITS'(w);
        r.rect_height  = RECT_HEIGHT_BITS'(h);
        return r;
    endfunction

    function automatic int pick_gap(bit no_idle);
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (roll < 75)
            return $urandom_range(0, 2);
        if (roll < 95)
            return $urandom_range(3, 15);
        return $urandom_range(40, 300);
    endfunction

    // Well-formed rectangles fit the strip; noise is zero sized, too wide or anything at all.
    function automatic in_item_t random_rect(bit first, bit noisy);
        int eff;
        int room;
        int rw;
        int rh;
        int pick;
        eff  = (sb.strip_width > MAX_COLS) ? MAX_COLS : int'(sb.strip_width);
        room = eff - 2 * int'(sb.margin);
        if (noisy || room < 1)
        begin
            pick = $urandom_range(0, 4);
            case (pick)
                0:
                begin
                    rw = 0;
                    rh = $urandom_range(0, 65535);
                end
                1:
                begin
                    rw = $urandom_range(0, 2047);
                    rh = 0;
                end
                2:
                begin
                    rw = $urandom_range((room < 0) ? 1 : room + 1, 2047);
                    rh = $urandom_range(1, 65535);
                end
                default:
                begin
                    rw = $urandom_range(0, 2047);
                    rh = $urandom_range(0, 65535);
                end
            endcase
        end
        else
        begin
            if ($urandom_range(0, 1))
                rw = $urandom_range(1, (room < 8) ? room : 8);
            else
                rw = $urandom_range(1, room);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                rh = $urandom_range(1, 2000);
            else if (pick < 9)
                rh = $urandom_range(1, 65535);
            else
                rh = 65535;
        end
        return rect(first, rw, rh);
    endfunction

    // Hold start until the item is taken; keep start high when no gap follows.
    task send_rect(in_item_t it, int gap);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_rect(it);
        rects_sent++;
        if (it.first_of_set)
            firsts_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task program_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_reg(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Drop start and wait until every placement is back and the block is idle.
    task wait_quiet();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
    endtask

    task set_strip(int strip, int gutter);
        wait_quiet();
        program_reg(CFG_STRIP_WIDTH, CFG_DATA_BITS'(strip), 1'b0);
        program_reg(CFG_BORDER_MARGIN, {3'($urandom_range(0, 7)), 8'(gutter)}, 1'b1);
        settings_run++;
    endtask

    task run_directed();
        // reset settings: full strip, no gutter
        send_rect(rect(1, 1, 1), pick_gap(0));
        send_rect(rect(0, 0, 7), pick_gap(0));
        send_rect(rect(0, 7, 0), pick_gap(0));
        // error with first set: no clear
        send_rect(rect(1, 0, 0), pick_gap(0));
        send_rect(rect(0, 1025, 1), pick_gap(0));
        send_rect(rect(1, 2047, 65535), pick_gap(0));
        send_rect(rect(0, 1024, 100), pick_gap(0));
        send_rect(rect(0, 1, 65535), pick_gap(0));
        // top lands exactly on the height limit
        send_rect(rect(1, 1024, 65535), pick_gap(0));
        send_rect(rect(0, 1, 1), pick_gap(0));
        send_rect(rect(1, 10, 20), pick_gap(0));
        send_rect(rect(0, 10, 5), pick_gap(0));
        send_rect(rect(0, 20, 3), pick_gap(0));
        send_rect(rect(0, 1004, 1), pick_gap(0));
        // widest gutter on an oversized strip setting
        set_strip(2047, 255);
        send_rect(rect(1, 514, 1), pick_gap(0));
        send_rect(rect(0, 515, 1), pick_gap(0));
        send_rect(rect(0, 514, 65025), pick_gap(0));
        // narrowed strip: columns past the edge keep their heights
        set_strip(8, 0);
        send_rect(rect(0, 8, 1), pick_gap(0));
        send_rect(rect(0, 9, 1), pick_gap(0));
        send_rect(rect(0, 3, 2), pick_gap(0));
        // empty strip: any nonzero width is too wide, a zero-size rectangle still reports zero size
        set_strip(0, 0);
        send_rect(rect(1, 1, 1), pick_gap(0));
        send_rect(rect(0, 0, 1), pick_gap(0));
        set_strip(1, 0);
        send_rect(rect(0, 1, 1), pick_gap(0));
        send_rect(rect(1, 1, 1), pick_gap(0));
    endtask

    task run_random();
        int  sent;
        int  phase;
        int  count;
        int  set_left;
        bit  no_idle;
        bit  noisy;
        bit  first;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_RECTS)
        begin
            case (phase)
                0: set_strip(1, 0);
                1: set_strip(1024, 255);
                2: set_strip(2047, 1);
                3: set_strip(0, 2);
                default:
                    set_strip(($urandom_range(0, 9) == 0) ? $urandom_range(97, 1024)
                                                          : $urandom_range(2, 96),
                              ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
            endcase
            count    = (phase == 3) ? 8 : $urandom_range(15, 35);
            no_idle  = ($urandom_range(0, 3) == 0);
            set_left = 0;
            repeat (count)
            begin
                noisy = ($urandom_range(0, 99) < 15);
                if (noisy)
                    first = $urandom_range(0, 1);
                else if (set_left == 0)
                begin
                    first    = 1'b1;
                    set_left = $urandom_range(2, 12);
                end
                else
                begin
                    first = 1'b0;
                    set_left--;
                end
                send_rect(random_rect(first, noisy), pick_gap(no_idle));
                sent++;
                if ($urandom_range(0, 49) == 0)
                    wait_quiet();
            end
            phase++;
        end
    endtask

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // let the store clear after reset, then poke the unused index once
        wait_quiet();
        program_reg(CFG_SPARE, CFG_DATA_BITS'($urandom_range(0, 2047)), 1'b1);
        run_directed();
        run_random();
        wait_quiet();
        repeat (40) @(posedge clk);
        sb.close_out();
        $display("covered %0d rectangles (%0d starting a set) over %0d strip settings, %0d checked",
                 rects_sent, firsts_sent, settings_run, sb.checked);
        $display("outcomes: placed %0d, zero size %0d, too wide %0d, height overflow %0d",
                 sb.status_count[STATUS_PLACED], sb.status_count[STATUS_ZERO],
                 sb.status_count[STATUS_WIDE], sb.status_count[STATUS_OVER]);
        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== height_map_rect_packer_unit.f =====
src/hmrp_pkg.sv
src/hmrp_ctrl.sv
src/hmrp_datapath.sv
src/height_map_rect_packer_unit.sv
dv/height_map_rect_packer_unit_test.sv
